@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdb assertion failed");

// The consequent must hold from the cycle after the antecedent.
`define PDB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdb assertion failed");

`endif

@@ rtl/pdb_pkg.sv @@
// Types, constants and decode functions of the pipeline decode bypass block.
// Depends on nothing; used by every module of the block.
package pdb_pkg;

	localparam int unsigned DataW    = 64;
	localparam int unsigned RegW     = 4;
	localparam int unsigned NumRegs  = 15;
	localparam int unsigned NumSlots = 5;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_BYPASS = 2'd1,
		OP_DECODE = 2'd2
	} op_t;

	localparam logic [3:0] IRRMOVQ = 4'd2;
	localparam logic [3:0] IIRMOVQ = 4'd3;
	localparam logic [3:0] IRMMOVQ = 4'd4;
	localparam logic [3:0] IMRMOVQ = 4'd5;
	localparam logic [3:0] IOPQ    = 4'd6;
	localparam logic [3:0] ICALL   = 4'd8;
	localparam logic [3:0] IRET    = 4'd9;
	localparam logic [3:0] IPUSHQ  = 4'd10;
	localparam logic [3:0] IPOPQ   = 4'd11;

	localparam logic [RegW-1:0] RSP   = 4'd4;
	localparam logic [RegW-1:0] RNONE = 4'd15;

	localparam logic [2:0] SLOT_EE = 3'd0;
	localparam logic [2:0] SLOT_ME = 3'd1;
	localparam logic [2:0] SLOT_MM = 3'd2;
	localparam logic [2:0] SLOT_WE = 3'd3;
	localparam logic [2:0] SLOT_WM = 3'd4;

	typedef logic [2:0] slot_idx_t;

	// Priority order of the bypass sources, highest first.
	localparam slot_idx_t ORDER_A [NumSlots] = '{SLOT_EE, SLOT_MM, SLOT_ME, SLOT_WE, SLOT_WM};
	localparam slot_idx_t ORDER_B [NumSlots] = '{SLOT_EE, SLOT_ME, SLOT_MM, SLOT_WE, SLOT_WM};

	typedef struct packed {
		logic [1:0]       operation;
		logic [3:0]       icode;
		logic [RegW-1:0]  reg_a;
		logic [RegW-1:0]  reg_b;
		logic [2:0]       slot;
		logic [RegW-1:0]  dest_reg;
		logic [DataW-1:0] value;
	} req_t;

	typedef struct packed {
		logic [RegW-1:0]  src_a;
		logic [RegW-1:0]  src_b;
		logic [RegW-1:0]  dst_e;
		logic [RegW-1:0]  dst_m;
		logic [DataW-1:0] val_a;
		logic [DataW-1:0] val_b;
	} rsp_t;

	// Registered outcome of the bypass search for one operand.
	typedef struct packed {
		logic             hit;
		logic [DataW-1:0] value;
	} fwd_t;

	function automatic logic [RegW-1:0] pick_src_a(logic [3:0] ic, logic [RegW-1:0] ra);
		logic [RegW-1:0] r;
		r = RNONE;
		if (ic inside {IRRMOVQ, IRMMOVQ, IOPQ, IPUSHQ}) r = ra;
		else if (ic inside {IPOPQ, IRET}) r = RSP;
		return r;
	endfunction

	function automatic logic [RegW-1:0] pick_src_b(logic [3:0] ic, logic [RegW-1:0] rb);
		logic [RegW-1:0] r;
		r = RNONE;
		if (ic inside {IOPQ, IRMMOVQ, IMRMOVQ}) r = rb;
		else if (ic inside {IPUSHQ, IPOPQ, ICALL, IRET}) r = RSP;
		return r;
	endfunction

	function automatic logic [RegW-1:0] pick_dst_e(logic [3:0] ic, logic [RegW-1:0] rb);
		logic [RegW-1:0] r;
		r = RNONE;
		if (ic inside {IRRMOVQ, IIRMOVQ, IOPQ}) r = rb;
		else if (ic inside {IPUSHQ, IPOPQ, ICALL, IRET}) r = RSP;
		return r;
	endfunction

	function automatic logic [RegW-1:0] pick_dst_m(logic [3:0] ic, logic [RegW-1:0] ra);
		logic [RegW-1:0] r;
		r = RNONE;
		if (ic inside {IMRMOVQ, IPOPQ}) r = ra;
		return r;
	endfunction

endpackage

@@ rtl/pipeline_decode_bypass.sv @@
// Y86-64 decode stage with register file and five-source bypass network.
// Depends on pdb_pkg, pdb_regfile and pdb_bypass.
// Path: a decode passes stage one and then the result register before it is on the outputs.
// Throughput: one transaction per cycle while the input is not stalled; a stalled result holds a decode in stage one.
// Reset: arst_n clears the register file valid bits, bypass sources and pipe valids.
module pipeline_decode_bypass (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pdb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pdb_pkg::rsp_t rsp
);
	import pdb_pkg::*;

	// Acceptance of a transaction and what kind it is. Register writes and
	// bypass updates take effect at the accepting edge and give no result.
	logic req_acc;
	logic wr_acc;
	logic set_acc;
	logic dec_acc;

	// Register selections worked out from the incoming instruction.
	logic [RegW-1:0] sel_src_a;
	logic [RegW-1:0] sel_src_b;

	// Stage one: selections, bypass search result and register file read.
	logic            vld_s1;
	logic [RegW-1:0] src_a_s1;
	logic [RegW-1:0] src_b_s1;
	logic [RegW-1:0] dst_e_s1;
	logic [RegW-1:0] dst_m_s1;
	fwd_t            fwd_a_s1;
	fwd_t            fwd_b_s1;
	logic [DataW-1:0] rd_a_s1;
	logic [DataW-1:0] rd_b_s1;

	// Result register.
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_next;
	logic out_free;

	assign req_acc = req_valid && !req_stall;
	assign wr_acc  = req_acc && (req.operation == OP_WRITE);
	assign set_acc = req_acc && (req.operation == OP_BYPASS);
	assign dec_acc = req_acc && (req.operation == OP_DECODE);

	// The result register can take stage one when it is empty or being drained.
	// Stage one only stalls the input while it holds a decode that cannot move.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = vld_s1 && !out_free;

	assign sel_src_a = pick_src_a(req.icode, req.reg_a);
	assign sel_src_b = pick_src_b(req.icode, req.reg_b);

	// The register file and bypass sources are read at the edge that accepts
	// the decode, so later writes cannot disturb an item waiting in stage one.
	pdb_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_acc),
		.wr_addr   (req.dest_reg),
		.wr_data   (req.value),
		.rd_en     (dec_acc),
		.rd_addr_a (sel_src_a),
		.rd_addr_b (sel_src_b),
		.rd_data_a (rd_a_s1),
		.rd_data_b (rd_b_s1)
	);

	pdb_bypass u_bypass (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_en    (set_acc),
		.set_slot  (req.slot),
		.set_dest  (req.dest_reg),
		.set_value (req.value),
		.look_en   (dec_acc),
		.src_a     (sel_src_a),
		.src_b     (sel_src_b),
		.fwd_a     (fwd_a_s1),
		.fwd_b     (fwd_b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (dec_acc) begin
			vld_s1 <= 1'b1;
		end else if (out_free) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			src_a_s1 <= sel_src_a;
			src_b_s1 <= sel_src_b;
			dst_e_s1 <= pick_dst_e(req.icode, req.reg_b);
			dst_m_s1 <= pick_dst_m(req.icode, req.reg_a);
		end
	end

	// A none source gives zero; otherwise a bypass hit beats the register file.
	always_comb begin
		rsp_next.src_a = src_a_s1;
		rsp_next.src_b = src_b_s1;
		rsp_next.dst_e = dst_e_s1;
		rsp_next.dst_m = dst_m_s1;
		if (src_a_s1 == RNONE) rsp_next.val_a = '0;
		else if (fwd_a_s1.hit) rsp_next.val_a = fwd_a_s1.value;
		else rsp_next.val_a = rd_a_s1;
		if (src_b_s1 == RNONE) rsp_next.val_b = '0;
		else if (fwd_b_s1.hit) rsp_next.val_b = fwd_b_s1.value;
		else rsp_next.val_b = rd_b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/pdb_regfile.sv @@
// Register file of the decode block: one write port and two registered read ports.
// Depends on pdb_pkg.
module pdb_regfile (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [pdb_pkg::RegW-1:0] wr_addr,
	input  logic [pdb_pkg::DataW-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [pdb_pkg::RegW-1:0] rd_addr_a,
	input  logic [pdb_pkg::RegW-1:0] rd_addr_b,
	output logic [pdb_pkg::DataW-1:0] rd_data_a,
	output logic [pdb_pkg::DataW-1:0] rd_data_b
);
	import pdb_pkg::*;

	logic [DataW-1:0]   mem_q [NumRegs];
	logic [NumRegs-1:0] vld_q;
	logic [DataW-1:0]   rd_a_q;
	logic [DataW-1:0]   rd_b_q;
	logic               wr_ok;

	// The none specifier addresses no entry, so writes to it are dropped.
	assign wr_ok = wr_en && (wr_addr != RNONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (rd_addr_a != RNONE && vld_q[rd_addr_a]) rd_a_q <= mem_q[rd_addr_a];
			else rd_a_q <= '0;
			if (rd_addr_b != RNONE && vld_q[rd_addr_b]) rd_b_q <= mem_q[rd_addr_b];
			else rd_b_q <= '0;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

@@ rtl/pdb_bypass.sv @@
// Bypass source registers and the priority search for both operands.
// Depends on pdb_pkg.
module pdb_bypass (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      set_en,
	input  logic [2:0]                set_slot,
	input  logic [pdb_pkg::RegW-1:0]  set_dest,
	input  logic [pdb_pkg::DataW-1:0] set_value,
	input  logic                      look_en,
	input  logic [pdb_pkg::RegW-1:0]  src_a,
	input  logic [pdb_pkg::RegW-1:0]  src_b,
	output pdb_pkg::fwd_t             fwd_a,
	output pdb_pkg::fwd_t             fwd_b
);
	import pdb_pkg::*;

	logic [RegW-1:0]  dest_q  [NumSlots];
	logic [DataW-1:0] value_q [NumSlots];
	fwd_t             fwd_a_q;
	fwd_t             fwd_b_q;
	fwd_t             find_a;
	fwd_t             find_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSlots; i++) begin
				dest_q[i]  <= RNONE;
				value_q[i] <= '0;
			end
		end else if (set_en && set_slot < 3'(NumSlots)) begin
			dest_q[set_slot]  <= set_dest;
			value_q[set_slot] <= set_value;
		end
	end

	// Walk from the lowest priority up so the first match in the order wins.
	always_comb begin
		find_a = '0;
		find_b = '0;
		for (int k = NumSlots - 1; k >= 0; k--) begin
			if (dest_q[ORDER_A[k]] == src_a) begin
				find_a.hit   = 1'b1;
				find_a.value = value_q[ORDER_A[k]];
			end
			if (dest_q[ORDER_B[k]] == src_b) begin
				find_b.hit   = 1'b1;
				find_b.value = value_q[ORDER_B[k]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (look_en) begin
			fwd_a_q <= find_a;
			fwd_b_q <= find_b;
		end
	end

	assign fwd_a = fwd_a_q;
	assign fwd_b = fwd_b_q;

endmodule

@@ rtl/pdb_checker.sv @@
// Port-level checks of the pipeline decode bypass block, bound to its top level.
// Depends on pdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input pdb_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pdb_pkg::rsp_t rsp
);
	import pdb_pkg::*;

	logic dec_acc;

	assign dec_acc = req_valid && !req_stall && (req.operation == OP_DECODE);

	// A stalled result transaction stays put.
	`PDB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// An operand with no source register is zero.
	`PDB_ASSERT_NOW(a_val_a_none, rsp_valid && rsp.src_a == RNONE, rsp.val_a == '0)
	`PDB_ASSERT_NOW(a_val_b_none, rsp_valid && rsp.src_b == RNONE, rsp.val_b == '0)

	// With the result side empty, an accepted decode is on display once it has passed stage one and the result register.
	`PDB_ASSERT_NEXT(a_dec_latency, dec_acc && !rsp_valid, ##1 rsp_valid)

endmodule

bind pipeline_decode_bypass pdb_checker u_pdb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
